// File: rtl/core/tpdr_pkg.sv
// Shared types and constants for the transport stream PID router.
package tpdr_pkg;

    localparam int PID_W     = 13;
    localparam int HITS_W    = 32;
    localparam int SLOT_CW   = 3;   // slot walk counter, holds up to four slots plus end
    localparam int BATCH_LEN = 7;
    localparam int CFG_IW    = 1;
    localparam int CFG_DW    = 4;

    localparam logic [2:0] OP_PACKET      = 3'd0;
    localparam logic [2:0] OP_WRITE_ENTRY = 3'd1;
    localparam logic [2:0] OP_WRITE_SLOT  = 3'd2;
    localparam logic [2:0] OP_STREAM_EN   = 3'd3;
    localparam logic [2:0] OP_READ_HITS   = 3'd4;

    localparam logic [1:0] KIND_ROUTED     = 2'd0;
    localparam logic [1:0] KIND_BYPASS     = 2'd1;
    localparam logic [1:0] KIND_COUNT      = 2'd2;
    localparam logic [1:0] KIND_BYPASS_OFF = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_BYPASS_ENABLE = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_BYPASS_STREAM = 1'd1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  header_byte1;
        logic [7:0]  header_byte2;
        logic [3:0]  entry_index;
        logic [12:0] table_pid;
        logic [1:0]  slot_index;
        logic [3:0]  target_stream;
        logic        flag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_stream;
        logic [2:0]  batch_position;
        logic        batch_full;
        logic [31:0] hit_count;
        logic        last;
    } out_item_t;

    // command held for the duration of one transaction, seen by every cell
    typedef struct packed {
        logic [2:0]       op;
        logic [PID_W-1:0] pid;
        logic [3:0]       entry_index;
        logic [PID_W-1:0] table_pid;
        logic [1:0]       slot_index;
        logic             flag;
    } cmd_t;

    // token and hit count lane passed from cell to cell
    typedef struct packed {
        logic              tok;
        logic [HITS_W-1:0] hits;
    } link_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] target;
    } slot_req_t;

    typedef struct packed {
        logic adv;
        logic ok;
    } slot_rsp_t;

endpackage

// File: rtl/core/tpdr_cell.sv
// One PID table entry: PID, active flag, stream slots and hit counter.
module tpdr_cell
    import tpdr_pkg::*;
#(
    parameter int IDX             = 0,
    parameter int SLOTS_PER_ENTRY = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  link_t     link_in,
    output link_t     link_out,
    input  slot_rsp_t rsp,
    output slot_req_t req
);

    localparam int SLW = (SLOTS_PER_ENTRY > 1) ? $clog2(SLOTS_PER_ENTRY) : 1;

    logic               tok_reg;
    logic [HITS_W-1:0]  lane_reg;
    logic [SLOT_CW-1:0] slot_reg;
    logic [PID_W-1:0]   pid_reg;
    logic               active_reg;
    logic [3:0]         tgt_reg  [SLOTS_PER_ENTRY];
    logic               sval_reg [SLOTS_PER_ENTRY];
    logic [HITS_W-1:0]  hits_reg;

    logic           match;
    logic           in_range;
    logic [SLW-1:0] sidx;
    logic           walking;
    logic           done;
    logic           my_entry;

    assign sidx     = slot_reg[SLW-1:0];
    assign my_entry = (cmd.entry_index == 4'(IDX));
    assign match    = (cmd.op == OP_PACKET) && active_reg && (pid_reg == cmd.pid);
    assign in_range = (slot_reg < SLOT_CW'(SLOTS_PER_ENTRY));

    always_comb
    begin
        walking = 1'b0;
        if (tok_reg && match && in_range)
        begin
            walking = sval_reg[sidx];
        end
    end

    assign done = tok_reg && !walking;

    assign req.valid  = walking;
    assign req.target = walking ? tgt_reg[sidx] : 4'd0;

    assign link_out.tok  = done;
    assign link_out.hits = ((cmd.op == OP_READ_HITS) && my_entry) ? hits_reg : lane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= 1'b0;
            slot_reg   <= '0;
            pid_reg    <= '0;
            active_reg <= 1'b0;
            hits_reg   <= '0;
            for (int i = 0; i < SLOTS_PER_ENTRY; i++)
            begin
                tgt_reg[i]  <= 4'd0;
                sval_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (link_in.tok)
            begin
                tok_reg  <= 1'b1;
                slot_reg <= '0;
            end
            else if (done)
            begin
                tok_reg <= 1'b0;
            end

            if (walking && rsp.adv)
            begin
                slot_reg <= slot_reg + 1'b1;
                if (rsp.ok)
                begin
                    hits_reg <= hits_reg + 1'b1;
                end
            end

            if (done && my_entry)
            begin
                if (cmd.op == OP_WRITE_ENTRY)
                begin
                    pid_reg    <= cmd.table_pid;
                    active_reg <= cmd.flag;
                end
                else if ((cmd.op == OP_WRITE_SLOT) &&
                         ({1'b0, cmd.slot_index} < 3'(SLOTS_PER_ENTRY)))
                begin
                    tgt_reg[cmd.slot_index[SLW-1:0]]  <= cmd.table_pid[3:0];
                    sval_reg[cmd.slot_index[SLW-1:0]] <= cmd.flag;
                end
            end
        end
    end

    // hit lane is payload, captured with the token
    always_ff @(posedge clk)
    begin
        if (link_in.tok)
        begin
            lane_reg <= link_in.hits;
        end
    end

endmodule

// File: rtl/core/ts_pid_demux_router_top.sv
// Transport stream PID router: command decode, stream table, result staging.
//
// Input channel (in_valid/in_ready/in_data) takes one command transaction at a time:
// a packet header, a table write, a stream enable write or a hit count read.
// Output channel (out_valid/out_ready/out_data) returns the results of that
// transaction in order; the final one carries last. Writes give no result.
// A packet visits the row of PID entry cells in order, one cell per cycle while
// no entry is walking; a matching entry holds the token while it walks its valid
// slots in order. A filtered packet, table write or hit count read passes the token
// along the whole row; bypass packets and stream enable writes skip the row.
// in_ready is high only between transactions. All results pass through a
// one-deep holding register into the output register, so the last flag can be
// set once the walk ends; a stalled receiver holds the walk in place.
// The config port (cfg_we/cfg_index/cfg_data) sets bypass mode and the master
// stream. It must be written only while the block is idle; the block does not check.
// Reset clears all tables, counters and config registers; the block is ready
// as soon as reset is released.
module ts_pid_demux_router_top
    import tpdr_pkg::*;
#(
    parameter int PID_ENTRIES     = 16,
    parameter int SLOTS_PER_ENTRY = 4,
    parameter int STREAM_COUNT    = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int SIW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHAIN = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;

    logic [1:0] state_reg, state_next;
    cmd_t       cmd_reg;
    logic       bypass_en_reg;
    logic [3:0] bypass_stream_reg;
    logic       stream_en_reg [STREAM_COUNT];
    logic [2:0] batch_reg     [STREAM_COUNT];
    logic       pend_valid_reg, pend_valid_next;
    out_item_t  pend_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;

    link_t      link [PID_ENTRIES+1];
    slot_req_t  reqs [PID_ENTRIES];
    slot_req_t  req;
    slot_rsp_t  rsp;
    logic [PID_ENTRIES-1:0] tok_vec;

    logic       accept;
    logic       bypass_pkt;
    logic       chain_op;
    logic       free;
    logic       tgt_ok;
    logic       m_ok;
    logic       ts_ok;
    logic       route_fire;
    logic [2:0] pos;
    logic       full;
    logic       rd_end;
    logic       new_valid;
    out_item_t  new_item;
    logic       load_out;
    out_item_t  out_load;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign bypass_pkt = (in_data.opcode == OP_PACKET) && bypass_en_reg;
    assign chain_op   = ((in_data.opcode == OP_PACKET) && !bypass_en_reg) ||
                        (in_data.opcode == OP_WRITE_ENTRY) ||
                        (in_data.opcode == OP_WRITE_SLOT) ||
                        (in_data.opcode == OP_READ_HITS);

    assign free = !out_valid_reg || out_ready;

    // chain entry and cells
    assign link[0].tok  = accept && chain_op;
    assign link[0].hits = '0;

    for (genvar g = 0; g < PID_ENTRIES; g++)
    begin : g_cell
        tpdr_cell #(
            .IDX             (g),
            .SLOTS_PER_ENTRY (SLOTS_PER_ENTRY)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd_reg),
            .link_in  (link[g]),
            .link_out (link[g+1]),
            .rsp      (rsp),
            .req      (reqs[g])
        );
        assign tok_vec[g] = link[g+1].tok;
    end

    // at most one cell holds the token, so OR-merging the requests is safe
    always_comb
    begin
        req = '0;
        for (int i = 0; i < PID_ENTRIES; i++)
        begin
            req.valid  = req.valid | reqs[i].valid;
            req.target = req.target | reqs[i].target;
        end
    end

    always_comb
    begin
        tgt_ok = 1'b0;
        pos    = 3'd0;
        if ({1'b0, req.target} < 5'(STREAM_COUNT))
        begin
            tgt_ok = stream_en_reg[req.target[SIW-1:0]];
            pos    = batch_reg[req.target[SIW-1:0]];
        end
    end

    always_comb
    begin
        m_ok = 1'b0;
        if ({1'b0, bypass_stream_reg} < 5'(STREAM_COUNT))
        begin
            m_ok = stream_en_reg[bypass_stream_reg[SIW-1:0]];
        end
    end

    assign ts_ok = ({1'b0, in_data.target_stream} < 5'(STREAM_COUNT));
    assign full  = (pos == 3'(BATCH_LEN - 1));

    assign rsp.adv    = !pend_valid_reg || free;
    assign rsp.ok     = tgt_ok;
    assign route_fire = req.valid && rsp.adv;
    assign rd_end     = (state_reg == ST_CHAIN) && link[PID_ENTRIES].tok &&
                        (cmd_reg.op == OP_READ_HITS);

    // new result into the holding register
    always_comb
    begin
        new_valid = 1'b0;
        new_item  = '0;
        priority if (accept && bypass_pkt)
        begin
            new_valid           = 1'b1;
            new_item.kind       = m_ok ? KIND_BYPASS : KIND_BYPASS_OFF;
            new_item.out_stream = bypass_stream_reg;
        end
        else if (rd_end)
        begin
            new_valid          = 1'b1;
            new_item.kind      = KIND_COUNT;
            new_item.hit_count = link[PID_ENTRIES].hits;
        end
        else if (route_fire && tgt_ok)
        begin
            new_valid               = 1'b1;
            new_item.kind           = KIND_ROUTED;
            new_item.out_stream     = req.target;
            new_item.batch_position = pos;
            new_item.batch_full     = full;
        end
    end

    assign load_out = pend_valid_reg &&
                      (new_valid || ((state_reg == ST_FIN) && free));

    always_comb
    begin
        out_load      = pend_reg;
        out_load.last = (state_reg == ST_FIN);
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (new_valid)
        begin
            pend_valid_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = chain_op ? ST_CHAIN : ST_FIN;
                end
            end
            ST_CHAIN:
            begin
                if (link[PID_ENTRIES].tok)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg || free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            bypass_en_reg     <= 1'b0;
            bypass_stream_reg <= 4'd0;
            for (int i = 0; i < STREAM_COUNT; i++)
            begin
                stream_en_reg[i] <= 1'b0;
                batch_reg[i]     <= 3'd0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;

            if (cfg_we && (cfg_index == CFG_BYPASS_ENABLE))
            begin
                bypass_en_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == CFG_BYPASS_STREAM))
            begin
                bypass_stream_reg <= cfg_data[3:0];
            end

            for (int i = 0; i < STREAM_COUNT; i++)
            begin
                if (accept && (in_data.opcode == OP_STREAM_EN) && ts_ok &&
                    (in_data.target_stream == 4'(i)))
                begin
                    stream_en_reg[i] <= in_data.flag;
                    batch_reg[i]     <= 3'd0;
                end
                else if (accept && bypass_pkt && m_ok && (bypass_stream_reg == 4'(i)))
                begin
                    batch_reg[i] <= 3'd0;   // bypass flushes the master's batch
                end
                else if (route_fire && tgt_ok && (req.target == 4'(i)))
                begin
                    batch_reg[i] <= full ? 3'd0 : pos + 3'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op          <= in_data.opcode;
            cmd_reg.pid         <= {in_data.header_byte1[4:0], in_data.header_byte2};
            cmd_reg.entry_index <= in_data.entry_index;
            // slot target rides in the low bits of table_pid for slot writes
            cmd_reg.table_pid   <= (in_data.opcode == OP_WRITE_SLOT) ?
                                   {9'd0, in_data.target_stream} : in_data.table_pid;
            cmd_reg.slot_index  <= in_data.slot_index;
            cmd_reg.flag        <= in_data.flag;
        end
        if (new_valid)
        begin
            pend_reg <= new_item;
        end
        if (load_out)
        begin
            out_reg <= out_load;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_idle_pend_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_valid_reg)
        else $error("holding register not empty between transactions");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell passing the token");

    a_walk_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (state_reg == ST_CHAIN))
        else $error("slot walk outside chain phase");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> free)
        else $error("output register overwritten while stalled");
`endif

endmodule

// File: test/tb_ts_pid_demux_router_top.sv
// Self-checking testbench for the transport stream PID router: directed, bypass, fan-out, random.
module tb_ts_pid_demux_router_top
    import tpdr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PID_ENTRIES     = 16;
    localparam int SLOTS_PER_ENTRY = 4;
    localparam int STREAM_COUNT    = 16;
    localparam int SLOT_STRIDE     = 4;
    localparam int SETTLE_CYCLES   = 100;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int FANOUT_PID      = 13'h0a5a;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    ts_pid_demux_router_top #(
        .PID_ENTRIES    (PID_ENTRIES),
        .SLOTS_PER_ENTRY(SLOTS_PER_ENTRY),
        .STREAM_COUNT   (STREAM_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Mirror of the router's tables and counters
    logic [12:0] tbl_pid    [PID_ENTRIES];
    logic        tbl_active [PID_ENTRIES];
    logic [3:0]  slot_tgt   [PID_ENTRIES*SLOT_STRIDE];
    logic        slot_vld   [PID_ENTRIES*SLOT_STRIDE];
    logic [31:0] tbl_hits   [PID_ENTRIES];
    logic        strm_en    [STREAM_COUNT];
    logic [2:0]  strm_batch [STREAM_COUNT];
    logic        byp_en;
    logic [3:0]  byp_strm;

    out_item_t   pending_routes[$];
    out_item_t   want_route;
    logic [12:0] pid_pool[4];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_req        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int cmds_sent       = 0;
    int results_checked = 0;
    int err_cnt         = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Routing prediction for one accepted command transaction
    function automatic void apply_cmd(input in_item_t c);
        out_item_t   r;
        out_item_t   prev;
        logic        have_prev;
        logic [12:0] pid;
        logic [3:0]  t;
        int          idx;
        int          pos;
        logic        full;
        logic        walking;

        have_prev = 1'b0;
        prev      = '0;
        case (c.opcode)
            OP_PACKET:
            begin
                if (byp_en)
                begin
                    r            = '0;
                    r.out_stream = byp_strm;
                    if (int'(byp_strm) < STREAM_COUNT && strm_en[byp_strm])
                    begin
                        strm_batch[byp_strm] = '0;
                        r.kind               = KIND_BYPASS;
                    end
                    else
                    begin
                        r.kind = KIND_BYPASS_OFF;
                    end
                    prev      = r;
                    have_prev = 1'b1;
                end
                else
                begin
                    pid = {c.header_byte1[4:0], c.header_byte2};
                    for (int e = 0; e < PID_ENTRIES; e++)
                    begin
                        if (tbl_active[e] && tbl_pid[e] == pid)
                        begin
                            walking = 1'b1;
                            for (int s = 0; s < SLOTS_PER_ENTRY; s++)
                            begin
                                idx = e * SLOT_STRIDE + s;
                                if (!slot_vld[idx])
                                    walking = 1'b0;
                                t = slot_tgt[idx];
                                if (walking && int'(t) < STREAM_COUNT && strm_en[t])
                                begin
                                    tbl_hits[e]   = tbl_hits[e] + 32'd1;
                                    pos           = int'(strm_batch[t]) % BATCH_LEN;
                                    full          = (pos + 1 == BATCH_LEN);
                                    strm_batch[t] = full ? 3'd0 : 3'(pos + 1);
                                    if (have_prev)
                                        pending_routes.push_back(prev);
                                    r                = '0;
                                    r.kind           = KIND_ROUTED;
                                    r.out_stream     = t;
                                    r.batch_position = 3'(pos);
                                    r.batch_full     = full;
                                    prev             = r;
                                    have_prev        = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            OP_WRITE_ENTRY:
            begin
                if (int'(c.entry_index) < PID_ENTRIES)
                begin
                    tbl_pid[c.entry_index]    = c.table_pid;
                    tbl_active[c.entry_index] = c.flag;
                end
            end
            OP_WRITE_SLOT:
            begin
                if (int'(c.entry_index) < PID_ENTRIES && int'(c.slot_index) < SLOTS_PER_ENTRY)
                begin
                    idx           = int'(c.entry_index) * SLOT_STRIDE + int'(c.slot_index);
                    slot_tgt[idx] = c.target_stream;
                    slot_vld[idx] = c.flag;
                end
            end
            OP_STREAM_EN:
            begin
                if (int'(c.target_stream) < STREAM_COUNT)
                begin
                    strm_en[c.target_stream]    = c.flag;
                    strm_batch[c.target_stream] = '0;
                end
            end
            OP_READ_HITS:
            begin
                r           = '0;
                r.kind      = KIND_COUNT;
                r.hit_count = (int'(c.entry_index) < PID_ENTRIES) ? tbl_hits[c.entry_index] : '0;
                prev        = r;
                have_prev   = 1'b1;
            end
            default: ;
        endcase
        if (have_prev)
        begin
            prev.last = 1'b1;
            pending_routes.push_back(prev);
        end
    endfunction

    function automatic in_item_t rand_fields();
        logic [63:0] raw;

        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    task automatic send_cmd(input in_item_t c);
        int gap;

        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (!in_ready);
        apply_cmd(c);
        cmds_sent++;
    endtask

    task automatic send_packet(input logic [7:0] b1, input logic [7:0] b2);
        in_item_t c;

        c              = rand_fields();
        c.opcode       = OP_PACKET;
        c.header_byte1 = b1;
        c.header_byte2 = b2;
        send_cmd(c);
    endtask

    task automatic write_entry(input logic [3:0] e, input logic [12:0] pid, input logic act);
        in_item_t c;

        c             = rand_fields();
        c.opcode      = OP_WRITE_ENTRY;
        c.entry_index = e;
        c.table_pid   = pid;
        c.flag        = act;
        send_cmd(c);
    endtask

    task automatic write_slot(input logic [3:0] e, input logic [1:0] s,
                              input logic [3:0] t, input logic v);
        in_item_t c;

        c               = rand_fields();
        c.opcode        = OP_WRITE_SLOT;
        c.entry_index   = e;
        c.slot_index    = s;
        c.target_stream = t;
        c.flag          = v;
        send_cmd(c);
    endtask

    task automatic set_stream(input logic [3:0] t, input logic en);
        in_item_t c;

        c               = rand_fields();
        c.opcode        = OP_STREAM_EN;
        c.target_stream = t;
        c.flag          = en;
        send_cmd(c);
    endtask

    task automatic read_hits(input logic [3:0] e);
        in_item_t c;

        c             = rand_fields();
        c.opcode      = OP_READ_HITS;
        c.entry_index = e;
        send_cmd(c);
    endtask

    // Drop valid, let every expected result arrive, then allow the walk to finish
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BYPASS_ENABLE)
            byp_en = val[0];
        else if (idx == CFG_BYPASS_STREAM)
            byp_strm = val;
        @(posedge clk);
    endtask

    function automatic in_item_t random_cmd();
        in_item_t    c;
        int          pick;
        logic [12:0] pid;

        c    = rand_fields();
        pick = $urandom_range(99);
        pid  = ($urandom_range(99) < 80) ? pid_pool[$urandom_range(3)] : c.table_pid;
        if (pick < 55)
        begin
            c.opcode       = OP_PACKET;
            c.header_byte1 = {c.header_byte1[7:5], pid[12:8]};
            c.header_byte2 = pid[7:0];
        end
        else if (pick < 67)
        begin
            c.opcode    = OP_WRITE_ENTRY;
            c.table_pid = pid;
            c.flag      = ($urandom_range(99) < 85);
        end
        else if (pick < 82)
        begin
            c.opcode = OP_WRITE_SLOT;
            c.flag   = ($urandom_range(99) < 80);
        end
        else if (pick < 90)
        begin
            c.opcode = OP_STREAM_EN;
            c.flag   = ($urandom_range(99) < 80);
        end
        else if (pick < 97)
        begin
            c.opcode = OP_READ_HITS;
        end
        else
        begin
            c.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        return c;
    endfunction

    function automatic in_item_t random_cmd_op(input logic [2:0] op);
        in_item_t c;

        c        = rand_fields();
        c.opcode = op;
        return c;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
            err_cnt = err_cnt + 1;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_routes.size() == 0)
            begin
                $error("unexpected result: kind %0d stream %0d", out_data.kind,
                       out_data.out_stream);
                err_cnt = err_cnt + 1;
            end
            else
            begin
                want_route = pending_routes.pop_front();
                check_field("kind", 32'(want_route.kind), 32'(out_data.kind));
                check_field("out_stream", 32'(want_route.out_stream), 32'(out_data.out_stream));
                check_field("batch_position", 32'(want_route.batch_position),
                            32'(out_data.batch_position));
                check_field("batch_full", 32'(want_route.batch_full), 32'(out_data.batch_full));
                check_field("hit_count", want_route.hit_count, out_data.hit_count);
                check_field("last", 32'(want_route.last), 32'(out_data.last));
                results_checked++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic test_reset_state();
        read_hits(4'd0);
        read_hits(4'd15);
        send_packet(8'h00, 8'h00);   // every entry inactive: no result
        settle_block();
    endtask

    task automatic test_directed_routing();
        set_stream(4'd3, 1'b1);
        set_stream(4'd15, 1'b1);
        write_entry(4'd0, 13'h1fff, 1'b1);
        write_entry(4'd15, 13'h1fff, 1'b1);
        write_slot(4'd0, 2'd0, 4'd3, 1'b1);
        write_slot(4'd0, 2'd1, 4'd5, 1'b1);    // disabled stream, skipped
        write_slot(4'd0, 2'd2, 4'd15, 1'b1);
        write_slot(4'd0, 2'd3, 4'd3, 1'b0);    // walk ends here
        write_slot(4'd15, 2'd0, 4'd15, 1'b1);
        write_slot(4'd15, 2'd2, 4'd3, 1'b1);   // behind an invalid slot, never reached
        // stream 15 takes two hits per packet, so the fourth packet completes a batch
        repeat (4) send_packet(8'hff, 8'hff);
        read_hits(4'd0);
        read_hits(4'd15);
        send_packet(8'he0, 8'h00);             // PID 0, no active match
        send_cmd(random_cmd_op(OP_UNUSED_LO));
        send_cmd(random_cmd_op(OP_UNUSED_HI));
        set_stream(4'd15, 1'b1);               // re-enable clears the batch count
        write_entry(4'd0, 13'h0000, 1'b0);
        send_packet(8'h1f, 8'hff);
        read_hits(4'd1);
        settle_block();
    endtask

    task automatic test_bypass();
        cfg_write(CFG_BYPASS_STREAM, 4'd15);
        cfg_write(CFG_BYPASS_ENABLE, 4'd1);
        send_packet(8'($urandom), 8'($urandom));
        send_packet(8'($urandom), 8'($urandom));
        read_hits(4'd15);
        set_stream(4'd15, 1'b0);
        send_packet(8'($urandom), 8'($urandom));
        settle_block();
        cfg_write(CFG_BYPASS_STREAM, 4'd0);
        send_packet(8'($urandom), 8'($urandom));   // master disabled
        set_stream(4'd0, 1'b1);
        send_packet(8'($urandom), 8'($urandom));
        settle_block();
        cfg_write(CFG_BYPASS_ENABLE, 4'd0);
        cfg_write(CFG_BYPASS_STREAM, 4'd3);
        send_packet(8'hff, 8'hff);
        settle_block();
    endtask

    // Every entry on one PID with all slots live: 64 results per packet
    task automatic test_full_fanout();
        for (int t = 0; t < STREAM_COUNT; t++)
            set_stream(4'(t), 1'b1);
        for (int e = 0; e < PID_ENTRIES; e++)
        begin
            write_entry(4'(e), 13'(FANOUT_PID), 1'b1);
            for (int s = 0; s < SLOTS_PER_ENTRY; s++)
                write_slot(4'(e), 2'(s), 4'(e + s), 1'b1);
        end
        send_packet(8'(FANOUT_PID >> 8), 8'(FANOUT_PID));
        send_packet(8'(FANOUT_PID >> 8) | 8'he0, 8'(FANOUT_PID));
        settle_block();
    endtask

    task automatic test_backpressure();
        hold_req = hold_req + 1;
        repeat (3) send_packet(8'(FANOUT_PID >> 8), 8'(FANOUT_PID));
        read_hits(4'd7);
        settle_block();
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        pid_pool[0]   = 13'h0000;
        pid_pool[1]   = 13'h1fff;
        pid_pool[2]   = 13'(FANOUT_PID);
        pid_pool[3]   = 13'($urandom);
        for (int i = 0; i < n_items; i++)
        begin
            if (i > 0 && i % 37 == 0)
            begin
                settle_block();
                cfg_write(CFG_BYPASS_STREAM, 4'($urandom));
                cfg_write(CFG_BYPASS_ENABLE, 4'($urandom_range(3) == 0));
            end
            send_cmd(random_cmd());
        end
        settle_block();
        cfg_write(CFG_BYPASS_ENABLE, 4'd0);
    endtask

    initial
    begin
        tbl_pid    = '{default: '0};
        tbl_active = '{default: '0};
        slot_tgt   = '{default: '0};
        slot_vld   = '{default: '0};
        tbl_hits   = '{default: '0};
        strm_en    = '{default: '0};
        strm_batch = '{default: '0};
        byp_en     = 1'b0;
        byp_strm   = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 65;
        test_reset_state();
        test_directed_routing();
        test_bypass();
        test_random_traffic(26, 65, 65);
        test_random_traffic(65, 26, 65);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_fanout();
        test_backpressure();
        test_random_traffic(0, 0, 65);

        $display("Covered table writes, stream enables, hit reads, bypass and 64-way fan-out");
        $display("under stalls and a long hold-off: %0d commands, %0d results checked.",
                 cmds_sent, results_checked);
        if (err_cnt == 0 && pending_routes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tpdr_pkg.sv
rtl/core/tpdr_cell.sv
rtl/core/ts_pid_demux_router_top.sv
test/tb_ts_pid_demux_router_top.sv
